// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define RAWU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rawu: same-cycle check failed");

// Next-cycle implication
`define RAWU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rawu: next-cycle check failed");

`endif

// ===== rtl/rawu_pkg.sv =====
package rawu_pkg;

  // Field widths
  localparam int SAMPLE_W    = 16;
  localparam int MEAN_W      = 16;
  localparam int HELD_W      = 9;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_PAD_W   = OUT_TDATA_W - MEAN_W - HELD_W;

  // Default window and the widths that follow from it
  localparam int WINDOW_DEF = 4;
  localparam int SUM_W_DEF  = SAMPLE_W + $clog2(WINDOW_DEF);
  localparam int CNT_W_DEF  = $clog2(WINDOW_DEF + 1);

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB,
    ST_LOAD,
    ST_DIV,
    ST_HOLD
  } rawu_state_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } rawu_div_stat_t;

endpackage

// ===== rtl/rawu_serdiv.sv =====
// Bit-serial restoring divider: signed dividend by unsigned nonzero divisor,
// quotient truncated toward zero. One quotient bit per cycle.
module rawu_serdiv #(
  parameter int DVD_W = rawu_pkg::SUM_W_DEF,
  parameter int DVS_W = rawu_pkg::CNT_W_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start_i,
  input  logic [DVD_W-1:0]            dvd_i,
  input  logic [DVS_W-1:0]            dvs_i,
  output rawu_pkg::rawu_div_stat_t    stat_o,
  output logic [rawu_pkg::MEAN_W-1:0] quo_o
);
  import rawu_pkg::*;

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic              neg_r;
  logic [DVD_W-1:0]  quo_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  dvs_r;

  logic [DVS_W:0]    rem_sh;
  logic              ge;
  logic [DVS_W:0]    diff;
  logic [DVS_W-1:0]  rem_nxt;
  logic [DVD_W-1:0]  res_full;

  // one restoring step: bring in next dividend bit, try subtract
  always_comb begin
    rem_sh  = {rem_r, quo_r[DVD_W-1]};
    ge      = (rem_sh >= {1'b0, dvs_r});
    diff    = rem_sh - {1'b0, dvs_r};
    rem_nxt = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
  end

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(DVD_W);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift registers: dividend bits leave at the top, quotient bits enter below
  always_ff @(posedge clk) begin
    if (start_i) begin
      neg_r <= dvd_i[DVD_W-1];
      quo_r <= dvd_i[DVD_W-1] ? (~dvd_i + 1'b1) : dvd_i;
      rem_r <= '0;
      dvs_r <= dvs_i;
    end else if (busy_r) begin
      quo_r <= {quo_r[DVD_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  // restore sign; magnitude of the mean always fits the sample range
  assign res_full    = neg_r ? (~quo_r + 1'b1) : quo_r;
  assign quo_o       = res_full[MEAN_W-1:0];
  assign stat_o.busy = busy_r;
  assign stat_o.done = done_r;

endmodule

// ===== rtl/running_average_window_unit.sv =====
// Channel | Dir | Handshake             | Word
// in_     | in  | in_tvalid/in_tready   | tdata[15:0] sample
// out_    | out | out_tvalid/out_tready | tdata[15:0] mean, [24:16] held, rest zero
//
// A new sample is taken only after the previous mean is in the output register.
// SUM_W = 16 + clog2(WINDOW); the bit-serial divider produces one quotient bit per cycle.
// Reset (rst_n low, synchronous) empties the window; store contents stay stale.
// A finished result sits in the output register, so the next word is taken
// while it waits; the divider's result holds until that register frees up.
`include "assert_macros.svh"

module running_average_window_unit #(
  parameter int WINDOW = rawu_pkg::WINDOW_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [rawu_pkg::IN_TDATA_W-1:0]  in_tdata,   // [15:0] sample
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rawu_pkg::OUT_TDATA_W-1:0] out_tdata   // [15:0] mean, [24:16] held
);
  import rawu_pkg::*;

  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [CNT_W-1:0] WIN_CNT  = CNT_W'(WINDOW);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(WINDOW - 1);

  rawu_state_t              state_r, state_nxt;
  logic [POS_W-1:0]         pos_r;
  logic [CNT_W-1:0]         cnt_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SAMPLE_W-1:0] smp_r;
  logic signed [SAMPLE_W-1:0] rd_r;
  logic [SAMPLE_W-1:0]      win_mem [WINDOW];

  logic                     out_valid_r;
  logic [MEAN_W-1:0]        out_mean_r;
  logic [HELD_W-1:0]        out_held_r;

  logic signed [SAMPLE_W-1:0] in_smp;
  logic                     accept;
  logic                     full;
  logic                     out_free;
  logic                     out_load;
  logic                     div_start;
  rawu_div_stat_t           div_stat;
  logic [MEAN_W-1:0]        div_quo;

  assign in_smp   = in_tdata[SAMPLE_W-1:0];
  assign accept   = in_tvalid && in_tready;
  assign full     = (cnt_r == WIN_CNT);
  assign out_free = !out_valid_r || out_tready;

  // sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // next state and strobes
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = ST_SUB;
      end
      ST_SUB:  state_nxt = ST_LOAD;
      ST_LOAD: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          if (out_free) begin
            out_load  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // window bookkeeping: add new sample on accept; in the next cycle drop oldest if full, else count it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      cnt_r <= '0;
      sum_r <= '0;
    end else if (accept) begin
      sum_r <= sum_r + SUM_W'(in_smp);
    end else if (state_r == ST_SUB) begin
      if (full) sum_r <= sum_r - SUM_W'(rd_r);
      else      cnt_r <= cnt_r + 1'b1;
      pos_r <= (pos_r == LAST_POS) ? '0 : pos_r + 1'b1;
    end
  end

  // sample store: read oldest on accept, overwrite it in the next cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      smp_r <= in_smp;
      rd_r  <= win_mem[pos_r];
    end
    if (state_r == ST_SUB) win_mem[pos_r] <= smp_r;
  end

  rawu_serdiv #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start),
    .dvd_i   (sum_r),
    .dvs_i   (cnt_r),
    .stat_o  (div_stat),
    .quo_o   (div_quo)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_mean_r <= div_quo;
      out_held_r <= HELD_W'(cnt_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_held_r, out_mean_r};

  // checks
  `RAWU_ASSERT_IMP(a_rdy_div_idle, in_tready, !div_stat.busy)
  `RAWU_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r <= WIN_CNT)
  `RAWU_ASSERT_IMP(a_done_in_div, div_stat.done, state_r == ST_DIV)
  `RAWU_ASSERT_NXT(a_acc_to_sub, accept, state_r == ST_SUB)
  `RAWU_ASSERT_IMP(a_out_held_nz, out_valid_r, out_held_r != '0)

endmodule
